// File: design/hpc_pkg.sv
`timescale 1ns / 1ps

package hpc_pkg;

  // control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CENTER,
    S_SEARCH,
    S_REFINE,
    S_DIV,
    S_EMIT
  } state_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD    = 2'd2;

  // register reset values
  localparam logic [8:0]  FRAME_WIDTH_RST  = 9'd224;
  localparam logic [8:0]  FRAME_HEIGHT_RST = 9'd224;
  localparam logic [15:0] THRESHOLD_RST    = 16'd6554;

endpackage

// File: design/hpc_pix_if.sv
`timescale 1ns / 1ps

interface hpc_pix_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        first_of_frame;
  logic [15:0] sample;

  modport source (output valid, output cmd, output first_of_frame, output sample,
                  input ready);
  modport sink (input valid, input cmd, input first_of_frame, input sample,
                output ready);
endinterface

// File: design/hpc_peak_if.sv
`timescale 1ns / 1ps

interface hpc_peak_if;
  logic        valid;
  logic        ready;
  logic [7:0]  peak_col;
  logic [7:0]  peak_row;
  logic [15:0] centroid_col;
  logic [15:0] centroid_row;
  logic [15:0] peak_level;
  logic        frame_done;

  modport source (output valid, output peak_col, output peak_row, output centroid_col,
                  output centroid_row, output peak_level, output frame_done,
                  input ready);
  modport sink (input valid, input peak_col, input peak_row, input centroid_col,
                input centroid_row, input peak_level, input frame_done,
                output ready);
endinterface

// File: design/heatmap_peak_centroid.sv
// Flow: each accepted beat is checked for a ready center; a center at or above threshold
//   has its search window scanned for a greater sample, then its refine window summed,
//   and the bit-serial divider forms the centroid before its result beat is shown.
// Throughput: a new beat is taken only when idle, once the last is through; the single read
//   port of the line store (one sample a cycle) and the bit-serial divider set the pace.
// Reset: synchronous; counters and sequencer clear, config presets; line store not cleared.
`timescale 1ns / 1ps

module heatmap_peak_centroid
  import hpc_pkg::*;
#(
  parameter int MAX_WIDTH     = 256,
  parameter int MAX_HEIGHT    = 256,
  parameter int SEARCH_RADIUS = 5,
  parameter int REFINE_RADIUS = 2,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  hpc_pix_if.sink     pix,
  hpc_peak_if.source  peaks
);

  localparam int LOOK_AHEAD = ((SEARCH_RADIUS - 1) > REFINE_RADIUS) ?
                              (SEARCH_RADIUS - 1) : REFINE_RADIUS;
  localparam int SLOTS = SEARCH_RADIUS + LOOK_AHEAD + 2;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(SLOTS);
  localparam int AW    = SW + XW;
  localparam int DEPTH = SLOTS << XW;
  localparam int CW    = $clog2(MAX_WIDTH + 1) + 1;
  localparam int RW    = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int NWIN  = (2 * REFINE_RADIUS + 1) * (2 * REFINE_RADIUS + 1);
  localparam int WS    = SAMPLE_BITS + $clog2(NWIN + 1);
  localparam int PW    = WS + (CW > RW ? CW : RW);
  localparam int NW    = PW + 8;
  localparam int DCW   = $clog2(NW + 1);

  // configuration registers
  logic [8:0]  frame_width;
  logic [8:0]  frame_height;
  logic [15:0] threshold;
  logic        cfg_wr;

  // sequencer
  state_t state, state_next;

  // input and evaluation position counters
  logic [CW-1:0] in_col, eval_col, c_col;
  logic [RW-1:0] in_row, eval_row, c_row;
  logic [SW-1:0] in_slot, eval_slot, c_slot;

  // line store
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;

  logic          pix_fire;
  logic [CW-1:0] w_eff, a_col;
  logic [RW-1:0] h_eff, a_row;
  logic [SW-1:0] a_slot;

  // center readiness
  logic [RW-1:0] row_last;
  logic [CW-1:0] col_last;
  logic          center_ready;

  // window scanner
  logic [SAMPLE_BITS-1:0] peak_v;
  logic [CW-1:0] sc_x, sc_x0, sc_x1, d_x;
  logic [RW-1:0] sc_y, sc_y1, d_y;
  logic [SW-1:0] sc_slot;
  logic          scanning, d_valid, greater, scan_done;
  logic [CW-1:0] s_x0, s_x1, r_x0, r_x1;
  logic [RW-1:0] s_y0, s_y1, r_y0, r_y1;
  logic [SW-1:0] s_slot0, r_slot0;
  logic [RW-1:0] s_diff, r_diff;

  // accumulators and divider
  logic [WS-1:0]  wsum;
  logic [PW-1:0]  acc_x, acc_y;
  logic [NW-1:0]  nx, ny;
  logic [WS-1:0]  rem_x, rem_y;
  logic [WS:0]    rsh_x, rsh_y;
  logic [DCW-1:0] div_cnt;
  logic           emit_load;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      threshold    <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[8:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[8:0];
        REG_THRESHOLD:    threshold    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = {23'd0, frame_width};
      REG_FRAME_HEIGHT: prdata = {23'd0, frame_height};
      REG_THRESHOLD:    prdata = {16'd0, threshold};
      default:          prdata = 32'd0;
    endcase
  end

  // effective geometry
  always_comb begin
    if (frame_width == 9'd0) w_eff = CW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(frame_width);
    if (frame_height == 9'd0) h_eff = RW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(frame_height);
  end

  // input side: position after an optional frame restart
  assign pix_fire = pix.valid && pix.ready;

  always_comb begin
    a_col  = in_col;
    a_row  = in_row;
    a_slot = in_slot;
    if (pix.first_of_frame) begin
      a_col  = '0;
      a_row  = '0;
      a_slot = '0;
    end
    wr_en   = pix_fire && !pix.cmd && (a_row < h_eff);
    wr_addr = {a_slot, a_col[XW-1:0]};
  end

  // center readiness: last pixel its windows need has arrived
  always_comb begin
    row_last = (eval_row + RW'(LOOK_AHEAD) < h_eff - RW'(1)) ?
               eval_row + RW'(LOOK_AHEAD) : h_eff - RW'(1);
    col_last = (eval_col + CW'(LOOK_AHEAD) < w_eff - CW'(1)) ?
               eval_col + CW'(LOOK_AHEAD) : w_eff - CW'(1);
    center_ready = (eval_row < h_eff) &&
                   ((row_last < in_row) || ((row_last == in_row) && (col_last < in_col)));
  end

  // window bounds around the held center
  always_comb begin
    s_x0 = (c_col > CW'(SEARCH_RADIUS)) ? c_col - CW'(SEARCH_RADIUS) : '0;
    s_x1 = (c_col + CW'(SEARCH_RADIUS) < w_eff) ? c_col + CW'(SEARCH_RADIUS) : w_eff;
    s_y0 = (c_row > RW'(SEARCH_RADIUS)) ? c_row - RW'(SEARCH_RADIUS) : '0;
    s_y1 = (c_row + RW'(SEARCH_RADIUS) < h_eff) ? c_row + RW'(SEARCH_RADIUS) : h_eff;
    r_x0 = (c_col > CW'(REFINE_RADIUS)) ? c_col - CW'(REFINE_RADIUS) : '0;
    r_x1 = (c_col + CW'(REFINE_RADIUS + 1) < w_eff) ? c_col + CW'(REFINE_RADIUS + 1) : w_eff;
    r_y0 = (c_row > RW'(REFINE_RADIUS)) ? c_row - RW'(REFINE_RADIUS) : '0;
    r_y1 = (c_row + RW'(REFINE_RADIUS + 1) < h_eff) ? c_row + RW'(REFINE_RADIUS + 1) : h_eff;
    s_diff = c_row - s_y0;
    r_diff = c_row - r_y0;
    s_slot0 = (RW'(c_slot) >= s_diff) ? SW'(RW'(c_slot) - s_diff) :
              SW'(RW'(c_slot) + RW'(SLOTS) - s_diff);
    r_slot0 = (RW'(c_slot) >= r_diff) ? SW'(RW'(c_slot) - r_diff) :
              SW'(RW'(c_slot) + RW'(SLOTS) - r_diff);
  end

  assign scan_done = !scanning && !d_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (pix_fire) state_next = S_CHECK;
      S_CHECK:  state_next = center_ready ? S_CENTER : S_IDLE;
      S_CENTER: state_next = (32'(rd_data) >= 32'(threshold)) ? S_SEARCH : S_IDLE;
      S_SEARCH: if (scan_done) state_next = greater ? S_IDLE : S_REFINE;
      S_REFINE: if (scan_done) state_next = S_DIV;
      S_DIV:    if (div_cnt == '0) state_next = S_EMIT;
      S_EMIT:   if (!peaks.valid || peaks.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pix.ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {sc_slot, sc_x[XW-1:0]};
    emit_load = 1'b0;
    unique case (state)
      S_IDLE:   pix.ready = 1'b1;
      S_CHECK: begin
        rd_en   = center_ready;
        rd_addr = {eval_slot, eval_col[XW-1:0]};
      end
      S_SEARCH, S_REFINE: rd_en = scanning;
      S_EMIT:   emit_load = !peaks.valid || peaks.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= SAMPLE_BITS'(pix.sample);
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col    <= '0;
      in_row    <= '0;
      in_slot   <= '0;
      eval_col  <= '0;
      eval_row  <= '0;
      eval_slot <= '0;
    end else begin
      if (pix_fire && !pix.cmd) begin
        in_col  <= a_col;
        in_row  <= a_row;
        in_slot <= a_slot;
        if (pix.first_of_frame) begin
          eval_col  <= '0;
          eval_row  <= '0;
          eval_slot <= '0;
        end
        if (a_row < h_eff) begin
          if (a_col + CW'(1) >= w_eff) begin
            in_col  <= '0;
            in_row  <= a_row + RW'(1);
            in_slot <= (a_slot == SW'(SLOTS - 1)) ? '0 : a_slot + SW'(1);
          end else begin
            in_col <= a_col + CW'(1);
          end
        end
      end
      if (state == S_CHECK && center_ready) begin
        if (eval_col + CW'(1) >= w_eff) begin
          eval_col  <= '0;
          eval_row  <= eval_row + RW'(1);
          eval_slot <= (eval_slot == SW'(SLOTS - 1)) ? '0 : eval_slot + SW'(1);
        end else begin
          eval_col <= eval_col + CW'(1);
        end
      end
    end
  end

  // held center
  always_ff @(posedge clk) begin
    if (state == S_CHECK && center_ready) begin
      c_col  <= eval_col;
      c_row  <= eval_row;
      c_slot <= eval_slot;
    end
    if (state == S_CENTER) peak_v <= rd_data;
  end

  // window scanner: one address a cycle, data compared or summed in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      d_valid  <= 1'b0;
    end else begin
      if ((state == S_SEARCH || state == S_REFINE) && scanning) begin
        d_valid <= 1'b1;
        d_x     <= sc_x;
        d_y     <= sc_y;
        if (sc_x + CW'(1) >= sc_x1) begin
          sc_x <= sc_x0;
          if (sc_y + RW'(1) >= sc_y1) begin
            scanning <= 1'b0;
          end else begin
            sc_y    <= sc_y + RW'(1);
            sc_slot <= (sc_slot == SW'(SLOTS - 1)) ? '0 : sc_slot + SW'(1);
          end
        end else begin
          sc_x <= sc_x + CW'(1);
        end
      end else begin
        d_valid <= 1'b0;
      end
      // search window setup
      if (state == S_CENTER && state_next == S_SEARCH) begin
        scanning <= 1'b1;
        sc_x     <= s_x0;
        sc_x0    <= s_x0;
        sc_x1    <= s_x1;
        sc_y     <= s_y0;
        sc_y1    <= s_y1;
        sc_slot  <= s_slot0;
      end
      // refine window setup
      if (state == S_SEARCH && state_next == S_REFINE) begin
        scanning <= 1'b1;
        sc_x     <= r_x0;
        sc_x0    <= r_x0;
        sc_x1    <= r_x1;
        sc_y     <= r_y0;
        sc_y1    <= r_y1;
        sc_slot  <= r_slot0;
      end
    end
  end

  // suppression test and weighted sums
  always_ff @(posedge clk) begin
    if (state == S_CENTER) greater <= 1'b0;
    else if (state == S_SEARCH && d_valid && rd_data > peak_v) greater <= 1'b1;
    if (state == S_SEARCH) begin
      wsum  <= '0;
      acc_x <= '0;
      acc_y <= '0;
    end else if (state == S_REFINE && d_valid) begin
      wsum  <= wsum + WS'(rd_data);
      acc_x <= acc_x + PW'(d_x * rd_data);
      acc_y <= acc_y + PW'(d_y * rd_data);
    end
  end

  // restoring divider, one quotient bit a cycle for both axes
  always_comb begin
    rsh_x = {rem_x, nx[NW-1]};
    rsh_y = {rem_y, ny[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (state == S_REFINE && scan_done) begin
      rem_x <= '0;
      rem_y <= '0;
      if (wsum == '0) begin
        nx      <= NW'(c_col) << 8;
        ny      <= NW'(c_row) << 8;
        div_cnt <= '0;
      end else begin
        nx      <= (NW'(acc_x) << 8) + NW'(wsum >> 1);
        ny      <= (NW'(acc_y) << 8) + NW'(wsum >> 1);
        div_cnt <= DCW'(NW);
      end
    end else if (state == S_DIV && div_cnt != '0) begin
      div_cnt <= div_cnt - DCW'(1);
      if (rsh_x >= {1'b0, wsum}) begin
        rem_x <= WS'(rsh_x - {1'b0, wsum});
        nx    <= {nx[NW-2:0], 1'b1};
      end else begin
        rem_x <= WS'(rsh_x);
        nx    <= {nx[NW-2:0], 1'b0};
      end
      if (rsh_y >= {1'b0, wsum}) begin
        rem_y <= WS'(rsh_y - {1'b0, wsum});
        ny    <= {ny[NW-2:0], 1'b1};
      end else begin
        rem_y <= WS'(rsh_y);
        ny    <= {ny[NW-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      peaks.valid <= 1'b0;
    end else if (emit_load) begin
      peaks.valid <= 1'b1;
    end else if (peaks.ready) begin
      peaks.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      peaks.peak_col     <= 8'(c_col);
      peaks.peak_row     <= 8'(c_row);
      peaks.centroid_col <= 16'(nx);
      peaks.centroid_row <= 16'(ny);
      peaks.peak_level   <= 16'(peak_v);
      peaks.frame_done   <= (c_col + CW'(1) >= w_eff) && (c_row + RW'(1) >= h_eff);
    end
  end

  // scanner only runs inside the window states
  a_scan_state: assert property (@(posedge clk) disable iff (rst)
    scanning |-> (state == S_SEARCH || state == S_REFINE))
    else $error("scanner active outside window states");

  // a center is only examined right after its readiness check
  a_center_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CENTER) |-> ($past(state) == S_CHECK))
    else $error("center read without readiness check");

  // a pending result is never overwritten
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && peaks.valid && !peaks.ready) |=> (state == S_EMIT))
    else $error("result dropped while output stalled");

  // store reads and writes never collide
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("line store read and write in the same cycle");

endmodule
